/* sv/texel_color_decoder_unit_assert.svh */
// Assertion macros shared by the decoder RTL.
`ifndef TEXEL_COLOR_DECODER_UNIT_ASSERT_SVH
`define TEXEL_COLOR_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define TCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define TCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tcd_pkg.sv */
package tcd_pkg;

    typedef logic [2:0]  cmd_t;
    typedef logic [15:0] word_t;
    typedef logic [31:0] color_t;

    localparam cmd_t FMT_ARGB1555 = 3'd0;
    localparam cmd_t FMT_RGB565   = 3'd1;
    localparam cmd_t FMT_ARGB4444 = 3'd2;
    localparam cmd_t FMT_YUV422   = 3'd3;
    localparam cmd_t FMT_RAW      = 3'd4;

    // 16.16 fixed-point BT.601 coefficients, wide enough for a 9-bit signed operand.
    localparam logic signed [25:0] COEF_RV = 26'sd91881;
    localparam logic signed [25:0] COEF_GU = 26'sd22554;
    localparam logic signed [25:0] COEF_GV = 26'sd46802;
    localparam logic signed [25:0] COEF_BU = 26'sd116130;
    localparam logic [8:0]         CHROMA_BIAS = 9'd128;

    function automatic logic [7:0] rep4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] rep5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] rep6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [7:0] sat_byte(input logic signed [10:0] x);
        logic [7:0] res;
        if (x < 0) begin
            res = 8'd0;
        end
        else if (x > 11'sd255) begin
            res = 8'd255;
        end
        else begin
            res = x[7:0];
        end
        return res;
    endfunction

endpackage

/* sv/tcd_convert.sv */
module tcd_convert
    import tcd_pkg::*;
(
    input  cmd_t   cmd,
    input  word_t  word_a,
    input  word_t  word_b,
    output color_t color_a,
    output color_t color_b
);

    logic signed [8:0]  u;
    logic signed [8:0]  v;
    logic signed [25:0] u_ext;
    logic signed [25:0] v_ext;
    logic signed [25:0] prod_rv;
    logic signed [25:0] prod_g;
    logic signed [25:0] prod_bu;
    logic signed [25:0] sh_rv;
    logic signed [25:0] sh_g;
    logic signed [25:0] sh_bu;
    color_t             yuv_a;
    color_t             yuv_b;

    function automatic color_t expand_word(input word_t w, input cmd_t fmt);
        color_t res;
        case (fmt)
            FMT_ARGB1555: res = {(w[15] ? 8'hff : 8'h00), rep5(w[4:0]),
                                 rep5(w[9:5]), rep5(w[14:10])};
            FMT_RGB565:   res = {8'hff, rep5(w[4:0]), rep6(w[10:5]), rep5(w[15:11])};
            FMT_ARGB4444: res = {rep4(w[15:12]), rep4(w[3:0]), rep4(w[7:4]),
                                 rep4(w[11:8])};
            default:      res = {8'hff, 8'h00, w[15:8], w[7:0]};
        endcase
        return res;
    endfunction

    function automatic color_t yuv_pixel(input logic [7:0] y,
                                         input logic signed [25:0] rv,
                                         input logic signed [25:0] g,
                                         input logic signed [25:0] bu);
        logic signed [10:0] ys;
        logic signed [10:0] r_sum;
        logic signed [10:0] g_sum;
        logic signed [10:0] b_sum;
        ys    = signed'({3'b000, y});
        r_sum = ys + rv[10:0];
        g_sum = ys - g[10:0];
        b_sum = ys + bu[10:0];
        return {8'hff, sat_byte(b_sum), sat_byte(g_sum), sat_byte(r_sum)};
    endfunction

    assign u     = signed'({1'b0, word_a[7:0]} - CHROMA_BIAS);
    assign v     = signed'({1'b0, word_b[7:0]} - CHROMA_BIAS);
    assign u_ext = signed'({{17{u[8]}}, u});
    assign v_ext = signed'({{17{v[8]}}, v});

    assign prod_rv = COEF_RV * v_ext;
    assign prod_g  = COEF_GU * u_ext + COEF_GV * v_ext;
    assign prod_bu = COEF_BU * u_ext;

    // Arithmetic shift gives floor rounding for negative products.
    assign sh_rv = prod_rv >>> 16;
    assign sh_g  = prod_g >>> 16;
    assign sh_bu = prod_bu >>> 16;

    assign yuv_a = yuv_pixel(word_a[15:8], sh_rv, sh_g, sh_bu);
    assign yuv_b = yuv_pixel(word_b[15:8], sh_rv, sh_g, sh_bu);

    always_comb
    begin
        if (cmd == FMT_YUV422) begin
            color_a = yuv_a;
            color_b = yuv_b;
        end
        else begin
            color_a = expand_word(word_a, cmd);
            color_b = expand_word(word_b, cmd);
        end
    end

endmodule

/* sv/texel_color_decoder_unit.sv */
// Channel   Handshake               Payload
// request   req_valid / req_ready   cmd, word_a, word_b
// response  rsp_valid / rsp_ready   color_a, color_b
//
// One request per cycle while rsp_ready stays high.
// The path is an input register, the format decode and YUV math, then a result register.
// Reset clears only the two valid flags; payload registers are not reset.
// A stalled response holds the result register, and the input register
// keeps taking requests until it too is full.
`include "texel_color_decoder_unit_assert.svh"

module texel_color_decoder_unit
    import tcd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  cmd_t   cmd,
    input  word_t  word_a,
    input  word_t  word_b,
    output logic   rsp_valid,
    input  logic   rsp_ready,
    output color_t color_a,
    output color_t color_b
);

    logic   s1_valid_reg;
    logic   s1_valid_next;
    cmd_t   cmd_reg;
    word_t  word_a_reg;
    word_t  word_b_reg;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    color_t color_a_reg;
    color_t color_b_reg;
    color_t color_a_next;
    color_t color_b_next;
    logic   out_load;
    logic   in_load;

    tcd_convert u_convert (
        .cmd     (cmd_reg),
        .word_a  (word_a_reg),
        .word_b  (word_b_reg),
        .color_a (color_a_next),
        .color_b (color_b_next)
    );

    // The result register takes a new value from a full input register when it is empty or being drained.
    assign out_load  = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || out_load;
    assign in_load   = req_valid && req_ready;

    always_comb
    begin
        s1_valid_next  = in_load || (s1_valid_reg && !out_load);
        rsp_valid_next = out_load || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load) begin
            cmd_reg    <= cmd;
            word_a_reg <= word_a;
            word_b_reg <= word_b;
        end
        if (out_load) begin
            color_a_reg <= color_a_next;
            color_b_reg <= color_b_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign color_a   = color_a_reg;
    assign color_b   = color_b_reg;

    `TCD_ASSERT_NOW(a_empty_takes_req, clk, rst_n, !s1_valid_reg, req_ready, "input stage empty but not ready")
    `TCD_ASSERT_NEXT(a_load_gives_rsp, clk, rst_n, out_load, rsp_valid, "loaded result not presented")
    `TCD_ASSERT_NEXT(a_stall_keeps_item, clk, rst_n, s1_valid_reg && rsp_valid_reg && !rsp_ready, s1_valid_reg, "pending request lost during stall")

endmodule

/* dv/tb_texel_color_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_texel_color_decoder_unit;
    import tcd_pkg::*;

    // Selector codes the block treats like the raw passthrough.
    localparam cmd_t FMT_SPARE_5 = 3'd5;
    localparam cmd_t FMT_SPARE_6 = 3'd6;
    localparam cmd_t FMT_SPARE_7 = 3'd7;

    localparam int RANDOM_CHUNKS  = 8;
    localparam int CHUNK_REQUESTS = 119;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        cmd_t  op;
        word_t wa;
        word_t wb;
    } texel_req_t;

    typedef struct packed {
        color_t ca;
        color_t cb;
    } rgba_pair_t;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   req_valid = 1'b0;
    logic   req_ready;
    cmd_t   cmd       = FMT_ARGB1555;
    word_t  word_a    = '0;
    word_t  word_b    = '0;
    logic   rsp_valid;
    logic   rsp_ready = 1'b0;
    color_t color_a;
    color_t color_b;

    texel_req_t pending_reqs[$];
    rgba_pair_t expected_colors[$];

    bit driving  = 1'b0;
    bit req_taken = 1'b0;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int pairs_checked = 0;
    int fmt_seen[8];

    texel_color_decoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .word_a    (word_a),
        .word_b    (word_b),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .color_a   (color_a),
        .color_b   (color_b)
    );

    always #10 clk = ~clk;

    function automatic logic [7:0] clamp_channel(input int x);
        if (x < 0)
            return 8'd0;
        if (x > 255)
            return 8'd255;
        return x[7:0];
    endfunction

    // Arithmetic shifts on int give floor rounding for negative products.
    function automatic color_t yuv_pixel(input int y, input int u, input int v);
        int r;
        int g;
        int b;
        r = y + ((int'(COEF_RV) * v) >>> 16);
        g = y - ((int'(COEF_GU) * u + int'(COEF_GV) * v) >>> 16);
        b = y + ((int'(COEF_BU) * u) >>> 16);
        return {8'hff, clamp_channel(b), clamp_channel(g), clamp_channel(r)};
    endfunction

    function automatic color_t expand_texel(input word_t w, input cmd_t op);
        case (op)
            FMT_ARGB1555:
                return {{8{w[15]}}, w[4:0], w[4:2], w[9:5], w[9:7], w[14:10], w[14:12]};
            FMT_RGB565:
                return {8'hff, w[4:0], w[4:2], w[10:5], w[10:9], w[15:11], w[15:13]};
            FMT_ARGB4444:
                return {w[15:12], w[15:12], w[3:0], w[3:0], w[7:4], w[7:4],
                        w[11:8], w[11:8]};
            default:
                return {8'hff, 8'h00, w[15:8], w[7:0]};
        endcase
    endfunction

    function automatic rgba_pair_t decode_pair(input texel_req_t rq);
        rgba_pair_t res;
        int u;
        int v;
        if (rq.op == FMT_YUV422) begin
            u = int'(rq.wa[7:0]) - int'(CHROMA_BIAS);
            v = int'(rq.wb[7:0]) - int'(CHROMA_BIAS);
            res.ca = yuv_pixel(int'(rq.wa[15:8]), u, v);
            res.cb = yuv_pixel(int'(rq.wb[15:8]), u, v);
        end
        else begin
            res.ca = expand_texel(rq.wa, rq.op);
            res.cb = expand_texel(rq.wb, rq.op);
        end
        return res;
    endfunction

    // Half the time pick a byte at a saturation or chroma-bias boundary.
    function automatic logic [7:0] corner_byte();
        logic [7:0] picks[7];
        picks = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'h81, 8'hfe, 8'hff};
        if ($urandom_range(1) == 0)
            return picks[$urandom_range(6)];
        return 8'($urandom);
    endfunction

    task automatic queue_request(input texel_req_t rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    task automatic note_mismatch(input string what, input color_t want, input color_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %08h, got %08h", what, want, got);
    endtask

    always @(posedge clk) begin : cycle_guard
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk) begin : drive_requests
        if (driving) begin
            // A request that was offered but not yet taken stays on the bus untouched.
            if (!(req_valid && !req_taken)) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    req_valid <= 1'b1;
                    cmd       <= pending_reqs[0].op;
                    word_a    <= pending_reqs[0].wa;
                    word_b    <= pending_reqs[0].wb;
                end
                else begin
                    req_valid <= 1'b0;
                end
            end
            rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin : watch_ports
        rgba_pair_t want;
        req_taken = rst_n && req_valid && req_ready;
        if (req_taken) begin
            if (pending_reqs.size() != 0)
                void'(pending_reqs.pop_front());
            expected_colors.insert(expected_colors.size(),
                                   decode_pair({cmd, word_a, word_b}));
            fmt_seen[cmd]++;
        end
        if (rst_n && rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("response with nothing pending: %08h %08h", color_a, color_b);
            end
            else begin
                want = expected_colors.pop_front();
                pairs_checked++;
                if (color_a !== want.ca)
                    note_mismatch("color_a", want.ca, color_a);
                if (color_b !== want.cb)
                    note_mismatch("color_b", want.cb, color_b);
            end
        end
    end

    initial begin : run_test
        texel_req_t rq;
        int idle_modes[4];
        int stall_modes[4];
        idle_modes  = '{0, 74, 0, 9};
        stall_modes = '{0, 0, 74, 9};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        driving = 1'b1;

        // Field extremes, the 1555 alpha bit, YUV saturation and every selector code.
        queue_request({FMT_ARGB1555, 16'h0000, 16'hffff});
        queue_request({FMT_ARGB1555, 16'h8000, 16'h7fff});
        queue_request({FMT_RGB565,   16'h0000, 16'hffff});
        queue_request({FMT_RGB565,   16'hf800, 16'h07e0});
        queue_request({FMT_ARGB4444, 16'h0000, 16'hffff});
        queue_request({FMT_ARGB4444, 16'hf000, 16'h0f0f});
        queue_request({FMT_YUV422,   16'h0080, 16'h0080});
        queue_request({FMT_YUV422,   16'h8080, 16'h8080});
        queue_request({FMT_YUV422,   16'hff00, 16'hffff});
        queue_request({FMT_YUV422,   16'h00ff, 16'h0000});
        queue_request({FMT_YUV422,   16'hffff, 16'hff00});
        queue_request({FMT_YUV422,   16'h0000, 16'h00ff});
        queue_request({FMT_YUV422,   16'h7f7f, 16'h8181});
        queue_request({FMT_RAW,      16'h1234, 16'habcd});
        queue_request({FMT_RAW,      16'h0000, 16'hffff});
        queue_request({FMT_SPARE_5,  16'h00ff, 16'hff00});
        queue_request({FMT_SPARE_6,  16'ha55a, 16'h5aa5});
        queue_request({FMT_SPARE_7,  16'hffff, 16'h0000});
        while (pending_reqs.size() != 0 || expected_colors.size() != 0)
            @(negedge clk);

        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            // Queues and pacing only change at a rising edge while the block is empty.
            @(posedge clk);
            sender_idle_pct = idle_modes[chunk % 4];
            stall_pct = stall_modes[chunk % 4];
            for (int i = 0; i < CHUNK_REQUESTS; i++) begin
                if ($urandom_range(9) == 0)
                    rq.op = cmd_t'($urandom_range(7, 5));
                else
                    rq.op = cmd_t'($urandom_range(4));
                if (rq.op == FMT_YUV422) begin
                    rq.wa = {corner_byte(), corner_byte()};
                    rq.wb = {corner_byte(), corner_byte()};
                end
                else begin
                    rq.wa = word_t'($urandom);
                    rq.wb = word_t'($urandom);
                end
                queue_request(rq);
            end
            while (pending_reqs.size() != 0 || expected_colors.size() != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d texel pairs: %0d ARGB1555, %0d RGB565, %0d ARGB4444, %0d YUV422,",
                 pairs_checked, fmt_seen[0], fmt_seen[1], fmt_seen[2], fmt_seen[3]);
        $display("%0d raw or unused selector; pacing ran free, sparse, back-pressured and mixed.",
                 fmt_seen[4] + fmt_seen[5] + fmt_seen[6] + fmt_seen[7]);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
